@@ design/keypad_matrix_scanner_macros.svh @@
// assertion helpers shared by the design files
`ifndef KEYPAD_MATRIX_SCANNER_MACROS_SVH
`define KEYPAD_MATRIX_SCANNER_MACROS_SVH
`define KMS_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("implication failed");
`define KMS_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("next-cycle check failed");
`endif

@@ design/kms_pkg.sv @@
// ----------------------------------------------------------------------------
// kms_pkg
// shared types and constants of the keypad matrix scanner
// ----------------------------------------------------------------------------
`default_nettype none
package kms_pkg;
    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int NKEYS = MAX_ROWS * MAX_COLS;
    localparam int KW = $clog2(NKEYS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int QDEPTH = 2;

    localparam logic [2:0] REG_ROWS = 3'd0;
    localparam logic [2:0] REG_COLS = 3'd1;
    localparam logic [2:0] REG_HIGH = 3'd2;
    localparam logic [2:0] REG_DEB  = 3'd3;
    localparam logic [2:0] REG_PHAN = 3'd4;
    localparam logic [2:0] REG_IRQ  = 3'd5;
    localparam logic [2:0] REG_MASK = 3'd6;

    localparam logic [1:0] WAIT_SETTLE = 2'd0;
    localparam logic [1:0] WAIT_DEB    = 2'd1;
    localparam logic [1:0] WAIT_POLL   = 2'd2;
    localparam logic [1:0] WAIT_IRQ    = 2'd3;

    localparam logic [1:0] DRV_NONE = 2'd0;
    localparam logic [1:0] DRV_ROW  = 2'd1;
    localparam logic [1:0] DRV_ALL  = 2'd2;

    // job from front to back
    typedef struct packed {
        logic       report;   // end of pass with reporting
        logic       phantom;  // run ghost removal first
        logic [1:0] mode;
        logic [RW-1:0] row;
        logic [1:0] wait_code;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE, B_PROW, B_PCOL, B_WALK, B_EMPTY
    } bstate_t;
endpackage
`default_nettype wire

@@ design/kms_front.sv @@
// ----------------------------------------------------------------------------
// kms_front
// samples one row per tick, keeps flags and press count, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none
module kms_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_column_sense,
    input  wire logic [3:0]           rows,
    input  wire logic [3:0]           cols,
    input  wire logic                 active_high,
    input  wire logic                 debounce_enable,
    input  wire logic                 phantom_enable,
    input  wire logic                 irq_mode,
    input  wire logic                 q_full,
    output logic                      q_push,
    output kms_pkg::job_t             q_job,
    input  wire logic                 back_busy,
    input  wire logic                 pk_we,
    input  wire logic [kms_pkg::NKEYS-1:0] pk_wdata,
    output logic [kms_pkg::NKEYS-1:0] pressed
);
    import kms_pkg::*;

    logic [NKEYS-1:0] pressed_reg, pressed_next;
    logic [3:0] row_reg, row_next;
    logic chg_reg, chg_next, lchg_reg, lchg_next;
    logic [1:0] pc_reg, pc_next;
    logic [KW-1:0] base;
    logic idle;
    job_t job;

    assign pressed = pressed_reg;
    // back owns the matrix while walking; wait until it is done
    assign s_ready = !q_full && !back_busy;
    assign q_push = s_valid && s_ready;
    assign q_job = job;
    assign base = KW'(row_reg[RW-1:0] * cols);
    assign idle = !active_high;

    always_comb begin
        logic [3:0] r;
        logic [1:0] pc;
        r = row_reg;
        pc = pc_reg;
        pressed_next = pressed_reg;
        chg_next = chg_reg;
        lchg_next = lchg_reg;
        job = '0;
        if (row_reg >= rows) begin
            r = '0;
            lchg_next = chg_reg;
            chg_next = 1'b0;
            pc = '0;
        end else begin
            for (int c = 0; c < MAX_COLS; c++) begin
                if (4'(c) < cols) begin
                    if (s_column_sense[c] ^ idle) begin
                        if (pc != 2'd3) pc = pc + 2'd1;
                        if (!pressed_reg[base + KW'(c)]) chg_next = 1'b1;
                        pressed_next[base + KW'(c)] = 1'b1;
                    end else begin
                        if (pressed_reg[base + KW'(c)]) chg_next = 1'b1;
                        pressed_next[base + KW'(c)] = 1'b0;
                    end
                end
            end
            r = row_reg + 4'd1;
        end
        pc_next = pc;
        row_next = r;
        if (r < rows) begin
            job.mode = DRV_ROW;
            job.row = r[RW-1:0];
            job.wait_code = WAIT_SETTLE;
        end else if (debounce_enable && chg_next) begin
            job.wait_code = WAIT_DEB;
        end else begin
            if (debounce_enable) chg_next = lchg_next;
            if (!irq_mode || pc != 2'd0) begin
                job.mode = DRV_NONE;
                job.wait_code = WAIT_POLL;
            end else begin
                job.mode = DRV_ALL;
                job.wait_code = WAIT_IRQ;
            end
            job.report = chg_next;
            job.phantom = chg_next && phantom_enable && pc == 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= '0;
            row_reg <= 4'(MAX_ROWS);
            chg_reg <= 1'b1;
            lchg_reg <= 1'b0;
            pc_reg <= '0;
        end else begin
            if (q_push) begin
                pressed_reg <= pressed_next;
                row_reg <= row_next;
                chg_reg <= chg_next;
                lchg_reg <= lchg_next;
                pc_reg <= pc_next;
            end else if (pk_we) begin
                pressed_reg <= pk_wdata;
            end
        end
    end

    `include "keypad_matrix_scanner_macros.svh"
    `KMS_ASSERT_IMP(a_no_push_full, aclk, aresetn, q_push, !q_full)
    `KMS_ASSERT_IMP(a_no_push_busy, aclk, aresetn, q_push, !back_busy)
    `KMS_ASSERT_IMP(a_ghost_cleanup_idle, aclk, aresetn, pk_we, !q_push)
endmodule
`default_nettype wire

@@ design/kms_back.sv @@
// ----------------------------------------------------------------------------
// kms_back
// job queue, ghost removal over rows and columns, event walk over keys
// ----------------------------------------------------------------------------
`default_nettype none
module kms_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_push,
    input  wire kms_pkg::job_t        q_job,
    output logic                      q_full,
    output logic                      busy,
    input  wire logic [3:0]           rows,
    input  wire logic [3:0]           cols,
    input  wire logic [kms_pkg::NKEYS-1:0] mapped_mask,
    input  wire logic [kms_pkg::NKEYS-1:0] pressed,
    output logic                      pk_we,
    output logic [kms_pkg::NKEYS-1:0] pk_wdata,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_drive_mode,
    output logic [2:0]                m_drive_row,
    output logic [1:0]                m_next_wait,
    output logic                      m_event_valid,
    output logic [5:0]                m_event_key,
    output logic                      m_event_pressed,
    output logic                      m_last_result
);
    import kms_pkg::*;

    job_t q_reg [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic pop;

    bstate_t st_reg, st_next;
    job_t cur_reg, cur_next;
    logic [NKEYS-1:0] pk_reg, pk_next, rep_reg, rep_next;
    logic [3:0] r_reg, r_next, c_reg, c_next;
    logic signed [4:0] first_reg, first_next;
    logic [KW:0] idx_reg, idx_next;
    logic any_reg, any_next;
    logic ov_reg, ov_next;
    logic [1:0] om_reg, om_next, ow_reg, ow_next;
    logic [RW-1:0] orow_reg, orow_next;
    logic oe_reg, oe_next, op_reg, op_next, ol_reg, ol_next;
    logic [KW-1:0] ok_reg, ok_next;
    logic [KW-1:0] hk_reg, hk_next;
    logic hp_reg, hp_next;
    logic we_next, we_reg;
    logic [KW:0] total;
    logic out_free;

    assign q_full = cnt_reg == 2'(QDEPTH);
    assign busy = st_reg != B_IDLE || cnt_reg != 2'd0 || ov_reg;
    assign out_free = !ov_reg || m_ready;
    assign total = (KW+1)'(rows * cols);
    assign pk_we = we_reg;
    assign pk_wdata = pk_reg;

    assign m_valid = ov_reg;
    assign m_drive_mode = om_reg;
    assign m_drive_row = 3'(orow_reg);
    assign m_next_wait = ow_reg;
    assign m_event_valid = oe_reg;
    assign m_event_key = 6'(ok_reg);
    assign m_event_pressed = op_reg;
    assign m_last_result = ol_reg;

    always_comb begin
        logic [KW-1:0] k;
        logic any;
        st_next = st_reg;
        cur_next = cur_reg;
        pk_next = pk_reg;
        rep_next = rep_reg;
        r_next = r_reg;
        c_next = c_reg;
        first_next = first_reg;
        idx_next = idx_reg;
        any_next = any_reg;
        ov_next = ov_reg && !m_ready;
        om_next = om_reg;
        ow_next = ow_reg;
        orow_next = orow_reg;
        oe_next = oe_reg;
        op_next = op_reg;
        ol_next = ol_reg;
        ok_next = ok_reg;
        hk_next = hk_reg;
        hp_next = hp_reg;
        we_next = 1'b0;
        pop = 1'b0;
        k = '0;
        any = 1'b0;
        case (st_reg)
            B_IDLE: begin
                if (cnt_reg != 2'd0 && out_free) begin
                    pop = 1'b1;
                    cur_next = q_reg[rp_reg];
                    pk_next = pressed;
                    any_next = 1'b0;
                    if (q_reg[rp_reg].phantom) begin
                        r_next = '0; c_next = '0; first_next = -5'sd1;
                        st_next = B_PROW;
                    end else if (q_reg[rp_reg].report) begin
                        idx_next = '0;
                        st_next = B_WALK;
                    end else begin
                        ov_next = 1'b1;
                        om_next = q_reg[rp_reg].mode;
                        orow_next = q_reg[rp_reg].row;
                        ow_next = q_reg[rp_reg].wait_code;
                        oe_next = 1'b0; ok_next = '0; op_next = 1'b0;
                        ol_next = 1'b1;
                    end
                end
            end
            // one row key per cycle; a column restore adds a parallel row scan
            B_PROW: begin
                if (r_reg >= rows) begin
                    idx_next = '0;
                    st_next = B_WALK;
                end else if (c_reg >= cols) begin
                    r_next = r_reg + 4'd1; c_next = '0; first_next = -5'sd1;
                end else begin
                    k = KW'(r_reg[RW-1:0] * cols + c_reg[CW-1:0]);
                    if (!pk_reg[k]) begin
                        c_next = c_reg + 4'd1;
                    end else if (first_reg == -5'sd1) begin
                        first_next = 5'(c_reg);
                        c_next = c_reg + 4'd1;
                    end else begin
                        if (first_reg >= 0) begin
                            for (int rr = 0; rr < MAX_ROWS; rr++) begin
                                if (4'(rr) > r_reg && 4'(rr) < rows) begin
                                    k = KW'(rr * cols + first_reg[CW-1:0]);
                                    if (pk_reg[k]) begin
                                        any = 1'b1;
                                        if (!rep_reg[k]) pk_next[k] = 1'b0;
                                    end
                                end
                            end
                            k = KW'(r_reg[RW-1:0] * cols + first_reg[CW-1:0]);
                        end
                        if (first_reg >= 0 && !any) begin
                            r_next = r_reg + 4'd1; c_next = '0; first_next = -5'sd1;
                        end else begin
                            if (first_reg >= 0) begin
                                if (!rep_reg[k]) pk_next[k] = 1'b0;
                                first_next = -5'sd2;
                            end
                            st_next = B_PCOL;
                        end
                    end
                end
            end
            B_PCOL: begin
                for (int rr = 0; rr < MAX_ROWS; rr++) begin
                    if (4'(rr) >= r_reg && 4'(rr) < rows) begin
                        k = KW'(rr * cols + c_reg[CW-1:0]);
                        if (pk_reg[k] && !rep_reg[k]) pk_next[k] = 1'b0;
                    end
                end
                c_next = c_reg + 4'd1;
                st_next = B_PROW;
            end
            B_WALK: begin
                if (out_free) begin
                    if (idx_reg >= total) begin
                        we_next = cur_reg.phantom;
                        st_next = B_IDLE;
                        if (!any_reg) begin
                            ov_next = 1'b1;
                            om_next = cur_reg.mode; orow_next = '0;
                            ow_next = cur_reg.wait_code;
                            oe_next = 1'b0; ok_next = '0; op_next = 1'b0;
                            ol_next = 1'b1;
                        end else begin
                            st_next = B_EMPTY;
                        end
                    end else begin
                        k = idx_reg[KW-1:0];
                        if (pk_reg[k] != rep_reg[k] && mapped_mask[k]) begin
                            // send the held event, hold this one
                            if (any_reg) begin
                                ov_next = 1'b1;
                                oe_next = 1'b1;
                                ol_next = 1'b0;
                                om_next = cur_reg.mode; orow_next = '0;
                                ow_next = cur_reg.wait_code;
                                ok_next = hk_reg; op_next = hp_reg;
                            end
                            hk_next = k; hp_next = pk_reg[k];
                            any_next = 1'b1;
                            rep_next[k] = pk_reg[k];
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            // flush the held last event with its last mark
            B_EMPTY: begin
                if (out_free) begin
                    ov_next = 1'b1; oe_next = 1'b1; ol_next = 1'b1;
                    om_next = cur_reg.mode; orow_next = '0;
                    ow_next = cur_reg.wait_code;
                    ok_next = hk_reg; op_next = hp_reg;
                    st_next = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= B_IDLE;
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
            ov_reg <= 1'b0;
            rep_reg <= '0;
            we_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            rep_reg <= rep_next;
            we_reg <= we_next;
            if (q_push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(q_push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) q_reg[wp_reg] <= q_job;
        cur_reg <= cur_next; pk_reg <= pk_next;
        r_reg <= r_next; c_reg <= c_next; first_reg <= first_next;
        idx_reg <= idx_next; any_reg <= any_next;
        om_reg <= om_next; ow_reg <= ow_next; orow_reg <= orow_next;
        oe_reg <= oe_next; op_reg <= op_next; ol_reg <= ol_next; ok_reg <= ok_next;
        hk_reg <= hk_next; hp_reg <= hp_next;
    end

    `include "keypad_matrix_scanner_macros.svh"
    `KMS_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, cnt_reg != 2'd0)
    `KMS_ASSERT_IMP(a_idle_ev, aclk, aresetn, m_valid && !m_event_valid, m_last_result)
    `KMS_ASSERT_NEXT(a_we_idle, aclk, aresetn, we_reg, st_reg == B_IDLE || st_reg == B_EMPTY)
endmodule
`default_nettype wire

@@ design/keypad_matrix_scanner.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_scanner
// row scanning keypad matrix with debounce rescan and ghost removal
// ----------------------------------------------------------------------------
// Each tick word returns one result word, except a tick that ends a reporting
// pass, which returns one word per changed mapped key, or a single word when
// no mapped key changed. A row tick's result word passes through the job
// queue and then the output register, and the next tick is taken only after
// the last result word of the previous one has left. An end-of-pass tick runs
// ghost removal first when its job asks for it, then walks the keys in the
// back walker (one key per cycle, a stalled result word holds the walk) and
// flushes the last held event if there is one; the next tick waits for all of
// it since the walk owns the pressed-key matrix.
`default_nettype none
module keypad_matrix_scanner (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_column_sense,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_drive_mode,
    output logic [2:0]      m_drive_row,
    output logic [1:0]      m_next_wait,
    output logic            m_event_valid,
    output logic [5:0]      m_event_key,
    output logic            m_event_pressed,
    output logic            m_last_result
);
    import kms_pkg::*;

    logic [3:0] nrows_reg, ncols_reg, rows, cols;
    logic high_reg, deb_reg, phan_reg, irq_reg;
    logic [NKEYS-1:0] mask_reg;
    logic q_full, q_push, back_busy, pk_we;
    job_t q_job;
    logic [NKEYS-1:0] pk_wdata, pressed;

    assign rows = (nrows_reg == 4'd0) ? 4'd1 :
                  (nrows_reg > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : nrows_reg;
    assign cols = (ncols_reg == 4'd0) ? 4'd1 :
                  (ncols_reg > 4'(MAX_COLS)) ? 4'(MAX_COLS) : ncols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrows_reg <= 4'd8; ncols_reg <= 4'd8;
            high_reg <= 1'b0; deb_reg <= 1'b0; phan_reg <= 1'b0; irq_reg <= 1'b0;
            mask_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS: nrows_reg <= cfg_data[3:0];
                REG_COLS: ncols_reg <= cfg_data[3:0];
                REG_HIGH: high_reg <= cfg_data[0];
                REG_DEB:  deb_reg <= cfg_data[0];
                REG_PHAN: phan_reg <= cfg_data[0];
                REG_IRQ:  irq_reg <= cfg_data[0];
                REG_MASK: mask_reg <= cfg_data[NKEYS-1:0];
                default: ;
            endcase
        end
    end

    kms_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_column_sense,
        .rows, .cols, .active_high(high_reg), .debounce_enable(deb_reg),
        .phantom_enable(phan_reg), .irq_mode(irq_reg),
        .q_full, .q_push, .q_job, .back_busy, .pk_we, .pk_wdata, .pressed
    );

    kms_back u_back (
        .aclk, .aresetn, .q_push, .q_job, .q_full, .busy(back_busy),
        .rows, .cols, .mapped_mask(mask_reg), .pressed, .pk_we, .pk_wdata,
        .m_valid, .m_ready, .m_drive_mode, .m_drive_row, .m_next_wait,
        .m_event_valid, .m_event_key, .m_event_pressed, .m_last_result
    );
endmodule
`default_nettype wire

@@ tb/kms_scan_checker.sv @@
// ----------------------------------------------------------------------------
// kms_scan_checker
// Watches the config port, the column word channel and the result channel of
// the keypad matrix scanner. Keeps its own copy of the scan state, works out
// the result words of every accepted tick and compares them in order with the
// words the block delivers.
// ----------------------------------------------------------------------------
module kms_scan_checker
    import kms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_column_sense,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_drive_mode,
    input  logic [2:0]  m_drive_row,
    input  logic [1:0]  m_next_wait,
    input  logic        m_event_valid,
    input  logic [5:0]  m_event_key,
    input  logic        m_event_pressed,
    input  logic        m_last_result,
    output int          fail_count,
    output int          words_owed
);
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] row;
        logic [1:0] wait_code;
        logic       ev;
        logic [5:0] key;
        logic       pressed;
        logic       last;
    } scan_word_t;

    scan_word_t owed_q[$];

    logic [3:0]  rows_r, cols_r;
    logic        high_r, deb_r, phan_r, irq_r;
    logic [63:0] mask_r;
    logic [63:0] down_keys, told_keys;
    int          row_pos, hit_count;
    logic        chg, last_chg;

    function automatic int rows_eff();
        return (rows_r == 0) ? 1 : (rows_r > MAX_ROWS) ? MAX_ROWS : int'(rows_r);
    endfunction

    function automatic int cols_eff();
        return (cols_r == 0) ? 1 : (cols_r > MAX_COLS) ? MAX_COLS : int'(cols_r);
    endfunction

    function automatic void drop_ghost(int idx);
        if (!told_keys[idx])
            down_keys[idx] = 1'b0;
    endfunction

    function automatic bit restore_column(int first, int col, int nr, int nc);
        bit any;
        any = 0;
        for (int r = first; r < nr; r++) begin
            if (down_keys[r*nc+col]) begin
                any = 1;
                drop_ghost(r*nc+col);
            end
        end
        return any;
    endfunction

    // -1 no key yet in this row, -2 several keys seen
    function automatic void clear_ghosts(int nr, int nc);
        int first;
        if (hit_count < 3)
            return;
        for (int r = 0; r < nr; r++) begin
            first = -1;
            for (int c = 0; c < nc; c++) begin
                if (!down_keys[r*nc+c])
                    continue;
                if (first == -1) begin
                    first = c;
                    continue;
                end
                if (first >= 0) begin
                    if (!restore_column(r + 1, first, nr, nc))
                        break;
                    drop_ghost(r*nc+first);
                    first = -2;
                end
                void'(restore_column(r, c, nr, nc));
            end
        end
    endfunction

    function automatic void push_word(logic [1:0] mode, logic [2:0] row, logic [1:0] wc,
                                      logic ev, logic [5:0] key, logic pr, logic last);
        scan_word_t w;
        w = '{mode, row, wc, ev, key, pr, last};
        owed_q.push_back(w);
    endfunction

    function automatic void predict_tick(logic [7:0] sense);
        int nr, nc, n, r;
        logic idle;
        logic [1:0] mode, wc;
        nr = rows_eff();
        nc = cols_eff();
        idle = !high_r;
        r = row_pos;
        n = 0;
        if (r >= nr) begin
            r = 0;
            last_chg = chg;
            chg = 0;
            hit_count = 0;
        end else begin
            for (int c = 0; c < nc; c++) begin
                if (sense[c] ^ idle) begin
                    if (hit_count < 3) hit_count++;
                    if (!down_keys[r*nc+c]) chg = 1;
                    down_keys[r*nc+c] = 1'b1;
                end else begin
                    if (down_keys[r*nc+c]) chg = 1;
                    down_keys[r*nc+c] = 1'b0;
                end
            end
            r++;
        end
        row_pos = r;
        if (r < nr) begin
            push_word(DRV_ROW, 3'(r), WAIT_SETTLE, 0, 0, 0, 1);
            return;
        end
        if (deb_r) begin
            if (chg) begin
                push_word(DRV_NONE, 0, WAIT_DEB, 0, 0, 0, 1);
                return;
            end
            chg = last_chg;
        end
        if (!irq_r || hit_count != 0) begin
            mode = DRV_NONE;
            wc = WAIT_POLL;
        end else begin
            mode = DRV_ALL;
            wc = WAIT_IRQ;
        end
        if (chg) begin
            if (phan_r)
                clear_ghosts(nr, nc);
            for (int idx = 0; idx < nr*nc; idx++) begin
                if (down_keys[idx] != told_keys[idx] && mask_r[idx]) begin
                    push_word(mode, 0, wc, 1, 6'(idx), down_keys[idx], 0);
                    n++;
                    told_keys[idx] = down_keys[idx];
                end
            end
        end
        if (n == 0)
            push_word(mode, 0, wc, 0, 0, 0, 1);
        else
            owed_q[owed_q.size()-1].last = 1;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        scan_word_t w;
        if (!aresetn) begin
            rows_r = 8; cols_r = 8;
            high_r = 0; deb_r = 0; phan_r = 0; irq_r = 0; mask_r = '0;
            down_keys = '0; told_keys = '0;
            row_pos = 8; chg = 1; last_chg = 0; hit_count = 0;
            owed_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROWS: rows_r = cfg_data[3:0];
                    REG_COLS: cols_r = cfg_data[3:0];
                    REG_HIGH: high_r = cfg_data[0];
                    REG_DEB:  deb_r  = cfg_data[0];
                    REG_PHAN: phan_r = cfg_data[0];
                    REG_IRQ:  irq_r  = cfg_data[0];
                    REG_MASK: mask_r = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected result word key %0d", $time, m_event_key);
                    fail_count++;
                end else begin
                    w = owed_q.pop_front();
                    check_field("drive_mode", w.mode, m_drive_mode);
                    check_field("drive_row", w.row, m_drive_row);
                    check_field("next_wait", w.wait_code, m_next_wait);
                    check_field("event_valid", w.ev, m_event_valid);
                    check_field("event_key", w.key, m_event_key);
                    check_field("event_pressed", w.pressed, m_event_pressed);
                    check_field("last_result", w.last, m_last_result);
                end
            end
            if (s_valid && s_ready)
                predict_tick(s_column_sense);
        end
        words_owed = owed_q.size();
    end

    initial begin
        fail_count = 0;
        words_owed = 0;
    end
endmodule

@@ tb/tb_keypad_matrix_scanner.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_matrix_scanner
// stimulus and verdict for the keypad matrix scanner
// ----------------------------------------------------------------------------
// Runs scan passes over held key patterns, including ghost corners and empty
// pads, through a set of configurations from one by one up to the full matrix,
// out-of-range counts, both polarities, debounce, ghost removal and interrupt
// mode. Mixed in are noise words. The sender works in bursts, the receiver
// stalls in changing patterns; the checker counts every mismatch.
// ----------------------------------------------------------------------------
module tb_keypad_matrix_scanner;
    import kms_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_column_sense = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_drive_mode;
    logic [2:0]  m_drive_row;
    logic [1:0]  m_next_wait;
    logic        m_event_valid;
    logic [5:0]  m_event_key;
    logic        m_event_pressed;
    logic        m_last_result;
    int          fail_count, words_owed;

    int          nrows = 8, ncols = 8, scan_pos = 8;
    logic        pol_high = 0;
    logic [7:0]  row_keys [8];
    int          burst_left = 0;
    int          ready_mode = 0;
    int          idle_cycles = 0;

    always #2 aclk = ~aclk;

    keypad_matrix_scanner u_dut (.*);

    kms_scan_checker u_chk (.*);

    // receiver stall pattern is redrawn at random among four patterns
    always @(posedge aclk) begin
        if ($urandom_range(63) == 0)
            ready_mode <= $urandom_range(3);
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(1);
            2: m_ready <= ($urandom_range(3) == 0);
            default: m_ready <= ($urandom_range(7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_keypad_matrix_scanner failed");
            $finish;
        end
    end

    task automatic write_regs(int r, int c, bit hi, bit deb, bit ph, bit irq,
                              logic [63:0] mask);
        logic [63:0] vals [7];
        vals = '{64'(r), 64'(c), 64'(hi), 64'(deb), 64'(ph), 64'(irq), mask};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        nrows = (r == 0) ? 1 : (r > 8) ? 8 : r;
        ncols = (c == 0) ? 1 : (c > 8) ? 8 : c;
        pol_high = hi;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_owed != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic new_pattern();
        int r1, r2, c1, c2;
        foreach (row_keys[i]) row_keys[i] = '0;
        case ($urandom_range(5))
            0: ;
            1: row_keys[$urandom_range(nrows-1)][$urandom_range(ncols-1)] = 1;
            2, 3: begin
                // three corners of a rectangle, the fourth maybe pressed too
                r1 = $urandom_range(nrows-1); r2 = $urandom_range(nrows-1);
                c1 = $urandom_range(ncols-1); c2 = $urandom_range(ncols-1);
                row_keys[r1][c1] = 1; row_keys[r1][c2] = 1; row_keys[r2][c1] = 1;
                if ($urandom_range(1)) row_keys[r2][c2] = 1;
            end
            default:
                repeat ($urandom_range(6)) row_keys[$urandom_range(nrows-1)]
                    [$urandom_range(ncols-1)] = 1;
        endcase
    endtask

    task automatic send_word(logic [7:0] v);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_column_sense <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_pos = (scan_pos >= nrows) ? 0 : scan_pos + 1;
    endtask

    task automatic run_ticks(int n);
        logic [7:0] v;
        for (int i = 0; i < n; i++) begin
            if (scan_pos >= nrows && $urandom_range(2) == 0)
                new_pattern();
            if ($urandom_range(9) == 0 || scan_pos >= nrows) begin
                v = $urandom;
            end else begin
                v = row_keys[scan_pos];
                for (int b = ncols; b < 8; b++) v[b] = $urandom_range(1);
                if (!pol_high) v = ~v;
            end
            send_word(v);
        end
    endtask

    initial begin
        logic [7:0] directed [18] = '{8'h00, 8'hFF, 8'hFF, 8'hFE, 8'h7F, 8'hAA, 8'h55,
                                      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'hFF,
                                      8'hFF, 8'hFF, 8'hFF, 8'hFF};
        foreach (row_keys[i]) row_keys[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults first, nothing mapped
        foreach (directed[i]) send_word(directed[i]);
        drain();

        write_regs(8, 8, 0, 0, 0, 0, '1);
        foreach (directed[i]) send_word(directed[i]);
        run_ticks(30);
        drain();
        write_regs(1, 1, 1, 0, 0, 0, '1);
        run_ticks(25);
        drain();
        write_regs(8, 8, 0, 1, 1, 0, '1);
        run_ticks(30);
        // sender holds until every word is back, mid-phase
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_owed != 0) @(posedge aclk);
        run_ticks(30);
        drain();
        write_regs(0, 15, 1, 0, 1, 1, {$urandom, $urandom});
        run_ticks(30);
        drain();
        write_regs(15, 0, 0, 1, 0, 1, '1);
        run_ticks(25);
        drain();
        write_regs(3, 5, 1, 1, 1, 1, {$urandom, $urandom});
        run_ticks(35);
        drain();
        write_regs(4, 4, 0, 0, 1, 0, '1);
        run_ticks(30);
        drain();
        write_regs(6, 7, 1, 0, 1, 1, 64'h0);
        run_ticks(15);
        drain();
        write_regs(6, 7, 1, 0, 1, 1, 64'hFFFF_FFFF_0000_FFFF);
        run_ticks(20);
        drain();
        write_regs(8, 2, 0, 1, 1, 0, {$urandom, $urandom});
        run_ticks(25);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_owed != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (fail_count == 0)
            $display("tb_keypad_matrix_scanner passed");
        else
            $display("tb_keypad_matrix_scanner failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/kms_pkg.sv
design/kms_front.sv
design/kms_back.sv
design/keypad_matrix_scanner.sv
tb/kms_scan_checker.sv
tb/tb_keypad_matrix_scanner.sv
